FILE: hdl/peg_pkg.sv
package peg_pkg;

  typedef enum logic [1:0] {
    MODE_SINGLE   = 2'd0,
    MODE_PERIODIC = 2'd1,
    MODE_GAUSS    = 2'd2,
    MODE_UNUSED   = 2'd3
  } shape_mode_t;

  typedef enum logic [2:0] {
    REG_SHAPE_MODE    = 3'd0,
    REG_RISE          = 3'd1,
    REG_HOLD          = 3'd2,
    REG_FALL          = 3'd3,
    REG_AMPLITUDE     = 3'd4,
    REG_BEGIN         = 3'd5,
    REG_PERIOD        = 3'd6,
    REG_PERIODIC_HOLD = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_ZERO  = 2'd0,
    KIND_AMP   = 2'd1,
    KIND_RAMP  = 2'd2,
    KIND_GAUSS = 2'd3
  } kind_t;

  typedef struct packed {
    shape_mode_t mode;
    logic [31:0] rise;
    logic [31:0] fall;
    logic [31:0] begin_ticks;
    logic [31:0] period;
    logic [32:0] b2_single;
    logic [32:0] b2_periodic;
    logic [33:0] b3_single;
    logic [33:0] b3_periodic;
    logic [33:0] total;
    logic [35:0] total3;
    logic [15:0] mag;
    logic        neg;
  } peg_cfg_t;

  localparam int DIV_W     = 34;
  localparam int DIV_STEPS = 30;
  localparam int REM_W     = 32;
  localparam int REM_STEPS = 32;
  localparam int R_FRAC    = 28;

  // Entry k of the exp table: exp(-16k/depth) in Q30, built by repeated
  // rounded multiplication with a Taylor-series step factor.
  function automatic logic [30:0] exp_entry(input logic [63:0] y, input int k);
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        q;
    logic [63:0]        e;
    term = 64'd1 << 30;
    sum  = 64'sd1 <<< 30;
    for (int n = 1; n <= 24; n++) begin
      term = ((term * y) >> 30) / 64'(n);
      if ((n % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    q = sum[63] ? 64'd0 : $unsigned(sum);
    e = 64'd1 << 30;
    for (int j = 1; j <= k; j++) begin
      e = (e * q + (64'd1 << 29)) >> 30;
    end
    return e[30:0];
  endfunction

endpackage

FILE: hdl/peg_config.sv
module peg_config (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output peg_pkg::peg_cfg_t   cfg
);

  peg_pkg::shape_mode_t mode;
  logic [31:0] rise;
  logic [31:0] hold;
  logic [31:0] fall;
  logic [15:0] amplitude;
  logic [31:0] begin_ticks;
  logic [31:0] period;
  logic [31:0] periodic_hold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= peg_pkg::MODE_SINGLE;
      rise          <= '0;
      hold          <= '0;
      fall          <= '0;
      amplitude     <= '0;
      begin_ticks   <= '0;
      period        <= '0;
      periodic_hold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (peg_pkg::cfg_reg_t'(cfg_index))
        peg_pkg::REG_SHAPE_MODE:    mode <= peg_pkg::shape_mode_t'(cfg_data[1:0]);
        peg_pkg::REG_RISE:          rise <= cfg_data;
        peg_pkg::REG_HOLD:          hold <= cfg_data;
        peg_pkg::REG_FALL:          fall <= cfg_data;
        peg_pkg::REG_AMPLITUDE:     amplitude <= cfg_data[15:0];
        peg_pkg::REG_BEGIN:         begin_ticks <= cfg_data;
        peg_pkg::REG_PERIOD:        period <= cfg_data;
        peg_pkg::REG_PERIODIC_HOLD: periodic_hold <= cfg_data;
        default: ;
      endcase
    end
  end

  // The segment boundaries and the gaussian span are precomputed once per
  // register change so that the datapath only compares against them.
  always_ff @(posedge clk) begin
    cfg.mode        <= mode;
    cfg.rise        <= rise;
    cfg.fall        <= fall;
    cfg.begin_ticks <= begin_ticks;
    cfg.period      <= period;
    cfg.b2_single   <= {1'b0, rise} + {1'b0, hold};
    cfg.b2_periodic <= {1'b0, rise} + {1'b0, periodic_hold};
    cfg.b3_single   <= {2'b0, rise} + {2'b0, hold} + {2'b0, fall};
    cfg.b3_periodic <= {2'b0, rise} + {2'b0, periodic_hold} + {2'b0, fall};
    cfg.total       <= {2'b0, rise} + {2'b0, hold} + {2'b0, fall};
    cfg.total3      <= {2'b0, rise, 1'b0} + {3'b0, rise} + {2'b0, hold, 1'b0} + {3'b0, hold}
                     + {2'b0, fall, 1'b0} + {3'b0, fall};
    cfg.mag         <= amplitude[15] ? (~amplitude + 16'd1) : amplitude;
    cfg.neg         <= amplitude[15];
  end

endmodule

FILE: hdl/peg_divider.sv
module peg_divider #(
  parameter int DEN_W  = 34,
  parameter int STEPS  = 30,
  parameter int SIDE_W = 2
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [DEN_W+STEPS-1:0]   dividend,
  input  logic [DEN_W-1:0]         divisor,
  input  logic [SIDE_W-1:0]        side,
  output logic                     out_valid,
  output logic [STEPS-1:0]         quotient,
  output logic [DEN_W-1:0]         remainder,
  output logic [SIDE_W-1:0]        out_side
);

  logic              vld     [STEPS];
  logic [DEN_W-1:0]  rem     [STEPS];
  logic [STEPS-1:0]  low     [STEPS];
  logic [STEPS-1:0]  quo     [STEPS];
  logic [DEN_W-1:0]  dvs     [STEPS];
  logic [SIDE_W-1:0] sd      [STEPS];

  logic              cur_vld [STEPS];
  logic [DEN_W-1:0]  cur_rem [STEPS];
  logic [STEPS-1:0]  cur_low [STEPS];
  logic [STEPS-1:0]  cur_quo [STEPS];
  logic [DEN_W-1:0]  cur_dvs [STEPS];
  logic [SIDE_W-1:0] cur_sd  [STEPS];
  logic [DEN_W:0]    trial   [STEPS];
  logic              ge      [STEPS];
  logic [DEN_W-1:0]  nxt_rem [STEPS];

  // One restoring step per stage: bring down the next dividend bit and
  // subtract the divisor when it fits.
  always_comb begin
    cur_vld[0] = in_valid;
    cur_rem[0] = dividend[DEN_W+STEPS-1:STEPS];
    cur_low[0] = dividend[STEPS-1:0];
    cur_quo[0] = '0;
    cur_dvs[0] = divisor;
    cur_sd[0]  = side;
    for (int s = 1; s < STEPS; s++) begin
      cur_vld[s] = vld[s-1];
      cur_rem[s] = rem[s-1];
      cur_low[s] = low[s-1];
      cur_quo[s] = quo[s-1];
      cur_dvs[s] = dvs[s-1];
      cur_sd[s]  = sd[s-1];
    end
    for (int s = 0; s < STEPS; s++) begin
      trial[s]   = {cur_rem[s], cur_low[s][STEPS-1]};
      ge[s]      = trial[s] >= {1'b0, cur_dvs[s]};
      nxt_rem[s] = ge[s] ? DEN_W'(trial[s] - {1'b0, cur_dvs[s]}) : trial[s][DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < STEPS; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (en) begin
      for (int s = 0; s < STEPS; s++) begin
        vld[s] <= cur_vld[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < STEPS; s++) begin
        rem[s] <= nxt_rem[s];
        low[s] <= cur_low[s] << 1;
        quo[s] <= {cur_quo[s][STEPS-2:0], ge[s]};
        dvs[s] <= cur_dvs[s];
        sd[s]  <= cur_sd[s];
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign quotient  = quo[STEPS-1];
  assign remainder = rem[STEPS-1];
  assign out_side  = sd[STEPS-1];

endmodule

FILE: hdl/peg_finish.sv
module peg_finish #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [29:0]             quotient,
  input  peg_pkg::kind_t          kind,
  input  logic [15:0]             mag,
  input  logic                    neg,
  output logic                    out_valid,
  output logic signed [15:0]      strength
);

  localparam int IDX_W   = $clog2(EXP_TABLE_DEPTH);
  localparam int DEPTH_W = $clog2(EXP_TABLE_DEPTH + 1);
  localparam logic [63:0] EXP_Y = (64'd16 << 30) / EXP_TABLE_DEPTH;

  logic [30:0] exp_rom [EXP_TABLE_DEPTH];

  for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [30:0] E_K = peg_pkg::exp_entry(EXP_Y, k);
    assign exp_rom[k] = E_K;
  end

  logic              v4, v5, v6, v7;
  peg_pkg::kind_t    k4, k5, k6;
  logic [15:0]       q4, q5, q6;
  logic [59:0]       sq4;
  logic              gz5, gz6;
  logic [IDX_W-1:0]  idx5;
  logic [30:0]       e6;
  logic [15:0]       m7;
  logic [36+DEPTH_W-1:0] idx_prod;
  logic [46:0]       gauss_prod;
  logic [15:0]       m_sel;

  assign idx_prod   = sq4[58:23] * DEPTH_W'(EXP_TABLE_DEPTH);
  assign gauss_prod = mag * e6;

  always_comb begin
    case (k6)
      peg_pkg::KIND_AMP:   m_sel = mag;
      peg_pkg::KIND_RAMP:  m_sel = q6;
      peg_pkg::KIND_GAUSS: m_sel = gz6 ? 16'd0 : gauss_prod[45:30];
      default:             m_sel = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v4        <= in_valid;
      v5        <= v4;
      v6        <= v5;
      v7        <= v6;
      out_valid <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k4       <= kind;
      q4       <= quotient[15:0];
      sq4      <= quotient * quotient;
      k5       <= k4;
      q5       <= q4;
      gz5      <= sq4[59];
      idx5     <= idx_prod[36 +: IDX_W];
      k6       <= k5;
      q6       <= q5;
      gz6      <= gz5;
      e6       <= exp_rom[idx5];
      m7       <= m_sel;
      strength <= neg ? $signed(~m7 + 16'd1) : $signed(m7);
    end
  end

endmodule

FILE: hdl/pulse_envelope_generator.sv
// Pulse envelope generator: one drive strength (signed Q1.14) for each
// elapsed time in ticks, as a single trapezoid, a periodic trapezoid after
// a silent lead-in, or a gaussian over the rise, hold and fall span.
// Requests enter on req_valid/req_stall with elapsed_ticks; results leave on
// res_valid/res_stall with strength, one result per request, in order.
// Registers are written on cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Write them only while no request is in flight.
// From acceptance to res_valid a request passes one input stage, a
// 32-stage remainder pipeline for the period fold, three setup stages, a
// 30-stage divider shared by the ramps and the gaussian, and five stages
// of squaring, table lookup and scaling.
// Throughput is one request per cycle. The whole pipeline advances together;
// while res_valid is high and res_stall is high, everything holds and
// req_stall is raised, so nothing is lost or repeated.
// Synchronous reset zeroes the config registers (single trapezoid, zero
// amplitude) and valid bits, emptying the pipeline; no clearing pass needed.
module pulse_envelope_generator #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [31:0]        elapsed_ticks,
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [15:0] strength,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  peg_pkg::peg_cfg_t cfg;
  logic en;

  assign en        = !(res_valid && res_stall);
  assign req_stall = !en;

  peg_config u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic        s0_valid;
  logic [31:0] s0_t;
  logic [31:0] s0_x;
  logic        s0_m1zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_t      <= elapsed_ticks;
      s0_x      <= elapsed_ticks - cfg.begin_ticks;
      s0_m1zero <= (elapsed_ticks <= cfg.begin_ticks) || (cfg.period == 32'd0);
    end
  end

  logic        rm_valid;
  logic [31:0] rm_rem;
  logic [32:0] rm_side;

  peg_divider #(
    .DEN_W  (peg_pkg::REM_W),
    .STEPS  (peg_pkg::REM_STEPS),
    .SIDE_W (33)
  ) u_rem (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s0_valid),
    .dividend  ({32'd0, s0_x}),
    .divisor   (cfg.period),
    .side      ({s0_m1zero, s0_t}),
    .out_valid (rm_valid),
    .quotient  (),
    .remainder (rm_rem),
    .out_side  (rm_side)
  );

  logic        mode1;
  logic [31:0] tt;
  logic [32:0] b2_sel;
  logic [33:0] b3_sel;
  logic [33:0] two_t;
  logic [33:0] a_abs;

  assign mode1  = cfg.mode == peg_pkg::MODE_PERIODIC;
  assign tt     = mode1 ? rm_rem : rm_side[31:0];
  assign b2_sel = mode1 ? cfg.b2_periodic : cfg.b2_single;
  assign b3_sel = mode1 ? cfg.b3_periodic : cfg.b3_single;
  assign two_t  = {1'b0, rm_side[31:0], 1'b0};
  assign a_abs  = (two_t >= cfg.total) ? (two_t - cfg.total) : (cfg.total - two_t);

  logic        s1_valid;
  logic [31:0] s1_tt;
  logic        s1_lt_r;
  logic        s1_lt_b2;
  logic        s1_lt_b3;
  logic        s1_zero;
  logic [33:0] s1_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= rm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tt    <= tt;
      s1_lt_r  <= tt < cfg.rise;
      s1_lt_b2 <= {1'b0, tt} < b2_sel;
      s1_lt_b3 <= {2'b0, tt} < b3_sel;
      s1_zero  <= mode1 && rm_side[32];
      s1_a     <= a_abs;
    end
  end

  peg_pkg::kind_t kind_c;
  logic [33:0]    num_c;
  logic [33:0]    den_c;

  always_comb begin
    kind_c = peg_pkg::KIND_ZERO;
    num_c  = '0;
    den_c  = '0;
    case (cfg.mode) inside
      peg_pkg::MODE_SINGLE, peg_pkg::MODE_PERIODIC: begin
        if (s1_zero) begin
          kind_c = peg_pkg::KIND_ZERO;
        end else if (s1_lt_r) begin
          kind_c = peg_pkg::KIND_RAMP;
          num_c  = {2'b0, s1_tt};
          den_c  = {2'b0, cfg.rise};
        end else if (s1_lt_b2) begin
          kind_c = peg_pkg::KIND_AMP;
        end else if (s1_lt_b3) begin
          kind_c = peg_pkg::KIND_RAMP;
          num_c  = b3_sel - {2'b0, s1_tt};
          den_c  = {2'b0, cfg.fall};
        end
      end
      peg_pkg::MODE_GAUSS: begin
        if (cfg.total != 34'd0 && {2'b0, s1_a} < cfg.total3) begin
          kind_c = peg_pkg::KIND_GAUSS;
          num_c  = s1_a;
          den_c  = cfg.total;
        end
      end
      default: kind_c = peg_pkg::KIND_ZERO;
    endcase
  end

  logic           s2_valid;
  peg_pkg::kind_t s2_kind;
  logic [33:0]    s2_num;
  logic [33:0]    s2_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_kind <= kind_c;
      s2_num  <= num_c;
      s2_den  <= den_c;
    end
  end

  logic           s3_valid;
  peg_pkg::kind_t s3_kind;
  logic [63:0]    s3_dividend;
  logic [33:0]    s3_divisor;
  logic [47:0]    ramp_prod;

  assign ramp_prod = cfg.mag * s2_num[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_kind     <= s2_kind;
      s3_divisor  <= s2_den;
      s3_dividend <= (s2_kind == peg_pkg::KIND_GAUSS)
                   ? {2'b0, s2_num, (peg_pkg::R_FRAC)'(0)}
                   : {16'd0, ramp_prod};
    end
  end

  logic        dv_valid;
  logic [29:0] dv_quot;
  logic [1:0]  dv_side;

  peg_divider #(
    .DEN_W  (peg_pkg::DIV_W),
    .STEPS  (peg_pkg::DIV_STEPS),
    .SIDE_W (2)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_valid),
    .dividend  (s3_dividend),
    .divisor   (s3_divisor),
    .side      (s3_kind),
    .out_valid (dv_valid),
    .quotient  (dv_quot),
    .remainder (),
    .out_side  (dv_side)
  );

  peg_finish #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_fin (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dv_valid),
    .quotient  (dv_quot),
    .kind      (peg_pkg::kind_t'(dv_side)),
    .mag       (cfg.mag),
    .neg       (cfg.neg),
    .out_valid (res_valid),
    .strength  (strength)
  );

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk) !rst && $past(rst) |-> !res_valid)
    else $error("result valid right after reset");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst) !en |=> res_valid)
    else $error("held result dropped during stall");
  a_stall_cause: assert property (@(posedge clk) req_stall |-> res_valid && res_stall)
    else $error("request stalled without a waiting result");
`endif

endmodule

FILE: sim/tb_pulse_envelope_generator.sv
`timescale 1ns / 1ps

module tb_pulse_envelope_generator;

  localparam int DEPTH = 256;
  localparam int LATENCY = 71;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [31:0] elapsed_ticks = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic signed [15:0] strength;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int errors = 0;
  int sent = 0;
  int received = 0;
  int config_sets = 0;

  always #6 clk = ~clk;

  pulse_envelope_generator #(.EXP_TABLE_DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .elapsed_ticks(elapsed_ticks),
    .res_valid(res_valid), .res_stall(res_stall), .strength(strength),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  class envelope_scoreboard;
    peg_pkg::shape_mode_t mode;
    logic [31:0] rise, hold, fall, begin_t, period, phold;
    logic signed [15:0] amp;
    logic [63:0] exp_q30[DEPTH];
    logic signed [15:0] pending[$];

    function new();
      logic [63:0] y, term, q;
      logic signed [63:0] sum;
      y = (64'd16 << 30) / DEPTH;
      term = 64'd1 << 30;
      sum = 64'sd1 <<< 30;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * y) >> 30) / 64'(n);
        if (n % 2 == 1) sum = sum - $signed(term);
        else sum = sum + $signed(term);
      end
      q = sum < 0 ? 64'd0 : $unsigned(sum);
      exp_q30[0] = 64'd1 << 30;
      for (int k = 1; k < DEPTH; k++) exp_q30[k] = (exp_q30[k-1] * q + (64'd1 << 29)) >> 30;
      clear();
    endfunction

    function void clear();
      mode = peg_pkg::MODE_SINGLE;
      rise = 0; hold = 0; fall = 0; begin_t = 0; period = 0; phold = 0; amp = 0;
    endfunction

    function void write_reg(peg_pkg::cfg_reg_t idx, logic [31:0] v);
      case (idx)
        peg_pkg::REG_SHAPE_MODE: mode = peg_pkg::shape_mode_t'(v[1:0]);
        peg_pkg::REG_RISE: rise = v;
        peg_pkg::REG_HOLD: hold = v;
        peg_pkg::REG_FALL: fall = v;
        peg_pkg::REG_AMPLITUDE: amp = v[15:0];
        peg_pkg::REG_BEGIN: begin_t = v;
        peg_pkg::REG_PERIOD: period = v;
        peg_pkg::REG_PERIODIC_HOLD: phold = v;
        default: ;
      endcase
    endfunction

    function logic signed [15:0] scaled(logic [63:0] num, logic [63:0] den);
      logic [63:0] mag, r;
      mag = amp < 0 ? 64'(-32'(amp)) : 64'(amp);
      r = mag * num / den;
      return amp < 0 ? -16'(r) : 16'(r);
    endfunction

    function logic signed [15:0] trapezoid(logic [63:0] t, logic [63:0] h);
      logic [63:0] r, f;
      r = rise; f = fall;
      if (t < r) return scaled(t, r);
      if (t < r + h) return amp;
      if (t < r + h + f) return scaled(f - (t - (r + h)), f);
      return 0;
    endfunction

    function logic signed [15:0] gaussian(logic [63:0] t);
      logic [63:0] total, a, rq, uq, idx, mag;
      total = 64'(rise) + hold + fall;
      if (total == 0) return 0;
      a = 2 * t >= total ? 2 * t - total : total - 2 * t;
      if (a >= 3 * total) return 0;
      rq = (a << 28) / total;
      uq = (rq * rq) >> 23;
      if (uq >= (64'd16 << 32)) return 0;
      idx = (uq * DEPTH) >> 36;
      if (idx >= DEPTH) return 0;
      mag = amp < 0 ? 64'(-32'(amp)) : 64'(amp);
      mag = (mag * exp_q30[idx]) >> 30;
      return amp < 0 ? -16'(mag) : 16'(mag);
    endfunction

    function void note_request(logic [31:0] ticks);
      logic signed [15:0] s;
      s = 0;
      case (mode)
        peg_pkg::MODE_SINGLE: s = trapezoid(ticks, hold);
        peg_pkg::MODE_PERIODIC:
          if (ticks > begin_t && period != 0)
            s = trapezoid(64'((ticks - begin_t) % period), phold);
        peg_pkg::MODE_GAUSS: s = gaussian(ticks);
        default: s = 0;
      endcase
      pending.push_back(s);
    endfunction

    task check_result(logic signed [15:0] got);
      logic signed [15:0] want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected strength %0d", got));
        return;
      end
      want = pending.pop_front();
      if (got !== want) report($sformatf("strength %0d, expected %0d", got, want));
    endtask
  endclass

  envelope_scoreboard board = new();

  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      board.check_result(strength);
      received++;
    end
  end

  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (rst) continue;
      if ($urandom_range(0, 7) == 0) begin
        g = gap_length() + 1;
        res_stall <= 1'b1;
        repeat (g) @(negedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(peg_pkg::cfg_reg_t idx, logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send(logic [31:0] ticks);
    int g;
    g = gap_length();
    if (g > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    elapsed_ticks <= ticks;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    board.note_request(ticks);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic setup(peg_pkg::shape_mode_t m, logic [31:0] r, logic [31:0] h,
                       logic [31:0] f, logic [15:0] a, logic [31:0] b, logic [31:0] p,
                       logic [31:0] ph);
    drain();
    write_reg(peg_pkg::REG_SHAPE_MODE, 32'(m));
    write_reg(peg_pkg::REG_RISE, r);
    write_reg(peg_pkg::REG_HOLD, h);
    write_reg(peg_pkg::REG_FALL, f);
    write_reg(peg_pkg::REG_AMPLITUDE, {16'($urandom_range(0, 65535)), a});
    write_reg(peg_pkg::REG_BEGIN, b);
    write_reg(peg_pkg::REG_PERIOD, p);
    write_reg(peg_pkg::REG_PERIODIC_HOLD, ph);
    config_sets++;
  endtask

  function automatic logic [31:0] small_dur();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom_range(1, 4);
      2: return $urandom_range(5, 300);
      3: return $urandom_range(300, 100000);
      4: return $urandom();
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_ticks();
    logic [63:0] span, edge_pt;
    span = 64'(board.rise) + board.hold + board.fall;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 3);
      3: edge_pt = 64'(board.rise);
      4: edge_pt = 64'(board.rise) + board.hold;
      5: edge_pt = span;
      6: edge_pt = span / 2;
      7: edge_pt = 64'(board.begin_t) + 64'(board.period) * $urandom_range(0, 4) +
                   $urandom_range(0, 3) * (64'(board.rise) + board.phold) / 2;
      default: edge_pt = span == 0 ? 64'($urandom()) : 64'($urandom()) % (span + span / 2 + 1);
    endcase
    edge_pt = edge_pt + $urandom_range(0, 2) - 1;
    return edge_pt > 64'hFFFF_FFFF ? $urandom() : edge_pt[31:0];
  endfunction

  initial begin
    logic [15:0] amps[6];
    peg_pkg::shape_mode_t m;
    amps = '{16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 16'h0001, 16'h0000};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    setup(peg_pkg::MODE_SINGLE, 10, 5, 20, 16'h7FFF, 0, 0, 0);
    for (int t = 0; t < 8; t++) send(32'(t * 5));
    send(32'hFFFF_FFFF);
    setup(peg_pkg::MODE_SINGLE, 0, 3, 0, 16'h8000, 0, 0, 0);
    send(0); send(2); send(3);
    setup(peg_pkg::MODE_PERIODIC, 4, 2, 4, 16'h4000, 100, 12, 3);
    send(100); send(101); send(105); send(112); send(32'hFFFF_FFFF);
    setup(peg_pkg::MODE_PERIODIC, 4, 2, 4, 16'h4000, 7, 0, 3);
    send(3); send(50);
    setup(peg_pkg::MODE_GAUSS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 0, 0, 0);
    send(0); send(32'hFFFF_FFFF);
    setup(peg_pkg::MODE_GAUSS, 0, 0, 0, 16'h7FFF, 0, 0, 0);
    send(5);
    setup(peg_pkg::MODE_UNUSED, 1, 1, 1, 16'h7FFF, 0, 1, 1);
    send(1);

    while (sent < 1050) begin
      m = peg_pkg::shape_mode_t'($urandom_range(0, 3) == 3 ? $urandom_range(0, 3)
                                                          : $urandom_range(0, 2));
      setup(m, small_dur(), small_dur(), small_dur(),
            $urandom_range(0, 1) ? amps[$urandom_range(0, 5)] : 16'($urandom()),
            small_dur(), $urandom_range(0, 3) == 0 ? small_dur() : $urandom_range(0, 400),
            small_dur());
      repeat ($urandom_range(20, 80)) send(pick_ticks());
    end
    drain();
    $display("Sent %0d requests across %0d register settings in all shape modes.",
             sent, config_sets);
    $display("Checked %0d strength results, %0d mismatches.", received, errors);
    if (errors == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("Timeout after %0d requests sent, %0d results.", sent, received);
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
